/* rtl/roam_variance_tree_unit_defines.svh */
// Assertion macros shared by the RTL of the variance tree unit.
// Each macro expands to one labeled concurrent assertion that is disabled during reset.
`ifndef ROAM_VARIANCE_TREE_UNIT_DEFINES_SVH
`define ROAM_VARIANCE_TREE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RVT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rvt_pkg.sv */
`timescale 1ns / 1ps

package rvt_pkg;

    // Geometry of the grid, the tree and the walk stack.
    localparam int GRID_SPAN   = 128;
    localparam int TREE_SIZE   = 2048;
    localparam int STACK_DEPTH = 16;

    localparam int GRID_DIM   = GRID_SPAN + 1;
    localparam int GRID_DEPTH = GRID_DIM * GRID_DIM;
    localparam int GRID_AW    = $clog2(GRID_DEPTH);
    localparam int COORD_W    = $clog2(GRID_DIM);
    localparam int NODE_W     = $clog2(TREE_SIZE) + 1;
    localparam int VAR_DEPTH  = 2 * TREE_SIZE;
    localparam int VAR_AW     = $clog2(VAR_DEPTH);
    localparam int SP_W       = $clog2(STACK_DEPTH + 1);
    localparam int SLOT_W     = $clog2(STACK_DEPTH);

    // Fixed field widths of the channels.
    localparam int REQ_W     = 2;
    localparam int XZ_W      = 8;
    localparam int H_W       = 16;
    localparam int NUM_W     = 11;
    localparam int RES_W     = 17;
    localparam int ERR_W     = 17;
    localparam int FRAC_BITS = 6;
    localparam int WHOLE_W   = H_W - FRAC_BITS;

    // Q10.6 value of 1.0 and the smallest side difference that still splits.
    localparam int Q_ONE     = 64;
    localparam int SPLIT_MIN = 3;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;

    typedef logic [COORD_W-1:0]      coord_t;
    typedef logic [NODE_W-1:0]       node_t;
    typedef logic [ERR_W-1:0]        err_t;
    typedef logic signed [H_W-1:0]   height_t;

    typedef struct packed {
        logic    en;
        coord_t  x;
        coord_t  z;
        height_t h;
    } grid_wr_t;

    typedef struct packed {
        logic   start;
        coord_t lx;
        coord_t lz;
        coord_t rx;
        coord_t rz;
    } err_req_t;

    typedef struct packed {
        logic done;
        err_t err;
    } err_rsp_t;

endpackage

/* rtl/rvt_ifs.sv */
`timescale 1ns / 1ps

interface rvt_req_if import rvt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [XZ_W-1:0]   grid_x;
    logic [XZ_W-1:0]   grid_z;
    logic signed [H_W-1:0] height_value;
    logic              tree_select;
    logic [NUM_W-1:0]  node_number;

    modport source (
        output valid, req_type, grid_x, grid_z, height_value, tree_select, node_number,
        input  ready
    );
    modport sink (
        input  valid, req_type, grid_x, grid_z, height_value, tree_select, node_number,
        output ready
    );
endinterface

interface rvt_rsp_if import rvt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [RES_W-1:0] result_value;
    logic             status;

    modport source (
        output valid, result_value, status,
        input  ready
    );
    modport sink (
        input  valid, result_value, status,
        output ready
    );
endinterface

/* rtl/rvt_grid_err.sv */
`timescale 1ns / 1ps

// Height grid memory and the per-triangle error unit. A start reads the left
// corner, the right corner and the hypotenuse midpoint on one read port, then
// forms the error and pulses done.
module rvt_grid_err import rvt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  grid_wr_t wr,
    input  err_req_t req,
    output err_rsp_t rsp
);

    localparam logic [1:0] SQ_IDLE = 2'd0;
    localparam logic [1:0] SQ_R    = 2'd1;
    localparam logic [1:0] SQ_C    = 2'd2;
    localparam logic [1:0] SQ_CALC = 2'd3;

    typedef logic signed [WHOLE_W-1:0] whole_t;

    height_t              grid_mem [GRID_DEPTH];
    height_t              rd_data_reg;
    logic [GRID_AW-1:0]   rd_addr;
    logic [1:0]           seq_reg;
    logic [1:0]           seq_next;
    coord_t               rx_reg;
    coord_t               rz_reg;
    coord_t               cx_reg;
    coord_t               cz_reg;
    whole_t               hl_reg;
    whole_t               hr_reg;
    err_t                 err_reg;
    logic                 done_reg;
    logic [COORD_W:0]     sum_x;
    logic [COORD_W:0]     sum_z;
    logic signed [WHOLE_W:0]  pair_sum;
    whole_t                   avg;
    logic signed [H_W+1:0]    diff;
    err_t                     err_abs;

    function automatic logic [GRID_AW-1:0] grid_addr(input coord_t x, input coord_t z);
        logic [GRID_AW-1:0] ax;
        ax = GRID_AW'(x);
        return GRID_AW'(ax * GRID_AW'(GRID_DIM)) + GRID_AW'(z);
    endfunction

    // Whole part of a Q10.6 sample, truncated toward zero.
    function automatic whole_t trunc_whole(input height_t h);
        logic signed [H_W:0] ext;
        ext = (H_W+1)'(h);
        if (h[H_W-1])
        begin
            ext = ext + (H_W+1)'(Q_ONE - 1);
        end
        return WHOLE_W'(ext >>> FRAC_BITS);
    endfunction

    assign sum_x = {1'b0, req.lx} + {1'b0, req.rx};
    assign sum_z = {1'b0, req.lz} + {1'b0, req.rz};

    always_comb
    begin
        case (seq_reg)
            SQ_IDLE: rd_addr = grid_addr(req.lx, req.lz);
            SQ_R:    rd_addr = grid_addr(rx_reg, rz_reg);
            SQ_C:    rd_addr = grid_addr(cx_reg, cz_reg);
            default: rd_addr = grid_addr(cx_reg, cz_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            grid_mem[grid_addr(wr.x, wr.z)] <= wr.h;
        end
        rd_data_reg <= grid_mem[rd_addr];
    end

    // Error is the absolute difference between the midpoint height and the floor average of the whole corner heights.
    always_comb
    begin
        pair_sum = (WHOLE_W+1)'(hl_reg) + (WHOLE_W+1)'(hr_reg);
        avg      = WHOLE_W'(pair_sum >>> 1);
        diff     = (H_W+2)'(rd_data_reg) - ((H_W+2)'(avg) <<< FRAC_BITS);
        err_abs  = diff[H_W+1] ? ERR_W'(-diff) : ERR_W'(diff);
    end

    always_comb
    begin
        seq_next = seq_reg;
        case (seq_reg)
            SQ_IDLE:
            begin
                if (req.start)
                begin
                    seq_next = SQ_R;
                end
            end
            SQ_R:    seq_next = SQ_C;
            SQ_C:    seq_next = SQ_CALC;
            default: seq_next = SQ_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg  <= SQ_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            seq_reg  <= seq_next;
            done_reg <= (seq_reg == SQ_CALC);
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_reg == SQ_IDLE && req.start)
        begin
            rx_reg <= req.rx;
            rz_reg <= req.rz;
            cx_reg <= sum_x[COORD_W:1];
            cz_reg <= sum_z[COORD_W:1];
        end
        if (seq_reg == SQ_R)
        begin
            hl_reg <= trunc_whole(rd_data_reg);
        end
        if (seq_reg == SQ_C)
        begin
            hr_reg <= trunc_whole(rd_data_reg);
        end
        if (seq_reg == SQ_CALC)
        begin
            err_reg <= err_abs;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.err  = err_reg;

endmodule

/* rtl/roam_variance_tree_unit.sv */
// Variance tree unit for level-of-detail tessellation of a square height grid.
// The req channel carries one item per request: a height load, a compute of one
// root triangle, or a read of one stored variance. The rsp channel returns
// exactly one item for every request, in order.
// A load returns its item in the cycle after acceptance; a read passes through
// the registered variance store read and then the output register. A compute
// walks the triangle depth first and returns the root error; each triangle
// takes three reads of the single grid read port and then an error calculation.
// Only one request is in flight at a time; the next one is taken once the unit
// is idle and the output register is empty or its result is being taken.
// After reset the variance store is swept to zero, one entry a cycle, over all
// 4096 entries, during which no request is accepted. The height grid is not cleared.
// If the receiver stalls, the result waits in the output register and no new
// request is accepted until it is taken.
`timescale 1ns / 1ps

`include "roam_variance_tree_unit_defines.svh"

module roam_variance_tree_unit import rvt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    rvt_req_if.sink      req,
    rvt_rsp_if.source    rsp
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RDV  = 3'd2;
    localparam logic [2:0] S_ERRW = 3'd3;
    localparam logic [2:0] S_STEP = 3'd4;

    // Progress of a frame: left child next, right child next, or ready to close.
    localparam logic [1:0] PH_LEFT  = 2'd0;
    localparam logic [1:0] PH_RIGHT = 2'd1;
    localparam logic [1:0] PH_CLOSE = 2'd2;

    typedef struct packed {
        coord_t lx;
        coord_t lz;
        coord_t rx;
        coord_t rz;
        coord_t ax;
        coord_t az;
    } frame_t;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [VAR_AW-1:0]   clr_addr_reg;
    logic [VAR_AW-1:0]   clr_addr_next;
    logic [SP_W-1:0]     sp_reg;
    logic [SP_W-1:0]     sp_next;
    logic                base_reg;
    logic                base_next;
    logic                hit_reg;
    logic                hit_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    logic [RES_W-1:0]    rsp_value_reg;
    logic                rsp_status_reg;

    // Walk stack, one frame per level in flight.
    frame_t              stk_frame_reg [STACK_DEPTH];
    node_t               stk_node_reg  [STACK_DEPTH];
    err_t                stk_err_reg   [STACK_DEPTH];
    logic [1:0]          stk_phase_reg [STACK_DEPTH];

    // Variance store with one write and one registered read port.
    logic [ERR_W-1:0]    var_mem [VAR_DEPTH];
    logic [ERR_W-1:0]    var_rd_reg;
    logic                var_we;
    logic [VAR_AW-1:0]   var_waddr;
    logic [ERR_W-1:0]    var_wdata;
    logic [VAR_AW-1:0]   var_raddr;

    logic                accept;
    logic                xz_in_range;
    logic                num_in_range;
    logic [SP_W-1:0]     sp_dec;
    logic [SP_W-1:0]     sp_dec2;
    logic [SLOT_W-1:0]   top_idx;
    logic [SLOT_W-1:0]   par_idx;
    logic [SLOT_W-1:0]   push_slot;
    frame_t              top_frame;
    node_t               top_node;
    err_t                top_err;
    logic [1:0]          top_phase;
    logic [COORD_W:0]    mid_x_sum;
    logic [COORD_W:0]    mid_z_sum;
    coord_t              mid_x;
    coord_t              mid_z;
    coord_t              dx;
    coord_t              dz;
    logic                node_in_tree;
    logic                split;
    logic                push_en;
    frame_t              push_frame;
    node_t               push_node;
    logic                phase_we;
    logic [1:0]          phase_val;
    logic                pop_upd;
    logic                out_load;
    logic [RES_W-1:0]    out_value;
    logic                out_status;
    logic                grid_we;
    grid_wr_t            grid_wr;
    err_req_t            err_req;
    err_rsp_t            err_rsp;

    rvt_grid_err u_grid_err (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (grid_wr),
        .req   (err_req),
        .rsp   (err_rsp)
    );

    assign req.ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.result_value = rsp_value_reg;
    assign rsp.status       = rsp_status_reg;

    assign xz_in_range  = ({1'b0, req.grid_x} <= (XZ_W+1)'(GRID_SPAN))
                       && ({1'b0, req.grid_z} <= (XZ_W+1)'(GRID_SPAN));
    assign num_in_range = (32'(req.node_number) < 32'(TREE_SIZE));
    assign var_raddr    = VAR_AW'(req.node_number)
                        + (req.tree_select ? VAR_AW'(TREE_SIZE) : VAR_AW'(0));

    // The frame on top of the stack and its parent.
    assign sp_dec    = sp_reg - SP_W'(1);
    assign sp_dec2   = sp_reg - SP_W'(2);
    assign top_idx   = sp_dec[SLOT_W-1:0];
    assign par_idx   = sp_dec2[SLOT_W-1:0];
    assign push_slot = sp_reg[SLOT_W-1:0];

    assign top_frame = stk_frame_reg[top_idx];
    assign top_node  = stk_node_reg[top_idx];
    assign top_err   = stk_err_reg[top_idx];
    assign top_phase = stk_phase_reg[top_idx];

    assign mid_x_sum = {1'b0, top_frame.lx} + {1'b0, top_frame.rx};
    assign mid_z_sum = {1'b0, top_frame.lz} + {1'b0, top_frame.rz};
    assign mid_x     = mid_x_sum[COORD_W:1];
    assign mid_z     = mid_z_sum[COORD_W:1];
    assign dx = (top_frame.lx > top_frame.rx) ? top_frame.lx - top_frame.rx
                                              : top_frame.rx - top_frame.lx;
    assign dz = (top_frame.lz > top_frame.rz) ? top_frame.lz - top_frame.rz
                                              : top_frame.rz - top_frame.lz;

    // A triangle is subdivided while its node lies inside the tree, a side is
    // long enough, and a free frame remains for the child.
    assign node_in_tree = (top_node < NODE_W'(TREE_SIZE));
    assign split = node_in_tree
                && ((dx >= COORD_W'(SPLIT_MIN)) || (dz >= COORD_W'(SPLIT_MIN)))
                && (sp_reg < SP_W'(STACK_DEPTH));

    assign grid_wr.en = grid_we;
    assign grid_wr.x  = COORD_W'(req.grid_x);
    assign grid_wr.z  = COORD_W'(req.grid_z);
    assign grid_wr.h  = req.height_value;

    assign err_req.start = push_en;
    assign err_req.lx    = push_frame.lx;
    assign err_req.lz    = push_frame.lz;
    assign err_req.rx    = push_frame.rx;
    assign err_req.rz    = push_frame.rz;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        sp_next       = sp_reg;
        base_next     = base_reg;
        hit_next      = hit_reg;
        push_en       = 1'b0;
        push_frame    = '0;
        push_node     = '0;
        phase_we      = 1'b0;
        phase_val     = PH_LEFT;
        pop_upd       = 1'b0;
        var_we        = 1'b0;
        var_waddr     = clr_addr_reg;
        var_wdata     = '0;
        out_load      = 1'b0;
        out_value     = '0;
        out_status    = 1'b0;
        grid_we       = 1'b0;

        case (state_reg)
            S_CLR:
            begin
                var_we        = 1'b1;
                clr_addr_next = clr_addr_reg + VAR_AW'(1);
                if (clr_addr_reg == VAR_AW'(VAR_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        REQ_LOAD:
                        begin
                            grid_we    = xz_in_range;
                            out_load   = 1'b1;
                            out_status = !xz_in_range;
                        end
                        REQ_COMPUTE:
                        begin
                            push_en   = 1'b1;
                            push_node = NODE_W'(1);
                            if (req.tree_select)
                            begin
                                push_frame = '{lx: COORD_W'(GRID_SPAN), lz: COORD_W'(GRID_SPAN),
                                               rx: '0, rz: '0,
                                               ax: COORD_W'(GRID_SPAN), az: '0};
                            end
                            else
                            begin
                                push_frame = '{lx: '0, lz: '0,
                                               rx: COORD_W'(GRID_SPAN), rz: COORD_W'(GRID_SPAN),
                                               ax: '0, az: COORD_W'(GRID_SPAN)};
                            end
                            base_next  = req.tree_select;
                            sp_next    = SP_W'(1);
                            state_next = S_ERRW;
                        end
                        REQ_READ:
                        begin
                            hit_next   = num_in_range;
                            state_next = S_RDV;
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end

            S_RDV:
            begin
                out_load   = 1'b1;
                out_value  = hit_reg ? RES_W'(var_rd_reg) : '0;
                state_next = S_IDLE;
            end

            S_ERRW:
            begin
                if (err_rsp.done)
                begin
                    state_next = S_STEP;
                end
            end

            S_STEP:
            begin
                case (top_phase)
                    PH_LEFT:
                    begin
                        if (split)
                        begin
                            phase_we   = 1'b1;
                            phase_val  = PH_RIGHT;
                            push_en    = 1'b1;
                            push_frame = '{lx: top_frame.ax, lz: top_frame.az,
                                           rx: top_frame.lx, rz: top_frame.lz,
                                           ax: mid_x, az: mid_z};
                            push_node  = {top_node[NODE_W-2:0], 1'b0};
                        end
                    end
                    PH_RIGHT:
                    begin
                        phase_we   = 1'b1;
                        phase_val  = PH_CLOSE;
                        push_en    = 1'b1;
                        push_frame = '{lx: top_frame.rx, lz: top_frame.rz,
                                       rx: top_frame.ax, rz: top_frame.az,
                                       ax: mid_x, az: mid_z};
                        push_node  = {top_node[NODE_W-2:0], 1'b1};
                    end
                    default:
                    begin
                        // Closing a subdivided triangle stores 1.0 plus its error.
                        var_we    = node_in_tree;
                        var_waddr = VAR_AW'(top_node)
                                  + (base_reg ? VAR_AW'(TREE_SIZE) : VAR_AW'(0));
                        var_wdata = top_err + ERR_W'(Q_ONE);
                    end
                endcase

                if (push_en)
                begin
                    sp_next    = sp_reg + SP_W'(1);
                    state_next = S_ERRW;
                end
                else
                begin
                    // The frame is finished: fold its error into the parent.
                    sp_next = sp_dec;
                    if (sp_dec == '0)
                    begin
                        out_load   = 1'b1;
                        out_value  = RES_W'(top_err);
                        state_next = S_IDLE;
                    end
                    else if (top_err > stk_err_reg[par_idx])
                    begin
                        pop_upd = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_addr_reg  <= '0;
            sp_reg        <= '0;
            base_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            sp_reg        <= sp_next;
            base_reg      <= base_next;
            hit_reg       <= hit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rsp_value_reg  <= out_value;
            rsp_status_reg <= out_status;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            stk_frame_reg[push_slot] <= push_frame;
            stk_node_reg[push_slot]  <= push_node;
            stk_phase_reg[push_slot] <= PH_LEFT;
        end
        if (phase_we)
        begin
            stk_phase_reg[top_idx] <= phase_val;
        end
        if (state_reg == S_ERRW && err_rsp.done)
        begin
            stk_err_reg[top_idx] <= err_rsp.err;
        end
        if (pop_upd)
        begin
            stk_err_reg[par_idx] <= top_err;
        end
    end

    // Variance store; reads and compute writes never fall in the same cycle.
    always_ff @(posedge clk)
    begin
        if (var_we)
        begin
            var_mem[var_waddr] <= var_wdata;
        end
        var_rd_reg <= var_mem[var_raddr];
    end

    `RVT_ASSERT_NOW(a_err_done_in_wait, clk, rst_n, err_rsp.done, state_reg == S_ERRW, "error result arrived outside the wait state")
    `RVT_ASSERT_NOW(a_step_stack_bounds, clk, rst_n, state_reg == S_STEP, (sp_reg != '0) && (sp_reg <= SP_W'(STACK_DEPTH)), "walk step with empty or overfull stack")
    `RVT_ASSERT_NOW(a_out_slot_free, clk, rst_n, out_load, !rsp_valid_reg || rsp.ready, "result loaded over an item not yet taken")
    `RVT_ASSERT_NEXT(a_wait_exit, clk, rst_n, state_reg == S_ERRW, (state_reg == S_ERRW) || (state_reg == S_STEP), "error wait left to an unexpected state")

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

// Testbench of the variance tree unit.
// Requests go in on one channel and every request returns exactly one result
// item, in order, on the other. A scoreboard object keeps its own copy of the
// height grid and of the variance store. It predicts each result when the
// request item is accepted and compares it with the result item that comes back.
module testbench;
    import rvt_pkg::*;

    // The request code that the block must ignore.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // A compute visits every triangle down to the leaves, and the watchdog limit
    // leaves room for a whole compute with nothing accepted.
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 50;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic [REQ_W-1:0]      kind;
        logic [XZ_W-1:0]       x;
        logic [XZ_W-1:0]       z;
        logic signed [H_W-1:0] h;
        logic                  tree;
        logic [NUM_W-1:0]      node;
    } request_t;

    typedef struct {
        logic [RES_W-1:0] value;
        logic             status;
    } result_t;

    // Holds the expected state of the block and the queue of results that are
    // still to come back.
    class variance_scoreboard;
        int               heights [GRID_DEPTH];
        bit               loaded [GRID_DEPTH];
        bit               touched [GRID_DEPTH];
        logic [RES_W-1:0] variance_mem [VAR_DEPTH];
        int unsigned      frame_crd [STACK_DEPTH][6];
        int unsigned      frame_node [STACK_DEPTH];
        int unsigned      frame_err [STACK_DEPTH];
        int               frame_phase [STACK_DEPTH];
        result_t          pending_results [$];
        int               mismatches;

        function new();
            foreach (heights[i])
            begin
                heights[i] = 0;
                loaded[i]  = 1'b0;
                touched[i] = 1'b0;
            end
            foreach (variance_mem[i])
                variance_mem[i] = '0;
            mismatches = 0;
        endfunction

        function int height_at(int unsigned x, int unsigned z);
            if (x > GRID_SPAN || z > GRID_SPAN)
                return 0;
            touched[x * GRID_DIM + z] = 1'b1;
            return heights[x * GRID_DIM + z];
        endfunction

        function int unsigned abs_diff(int unsigned a, int unsigned b);
            return (a > b) ? a - b : b - a;
        endfunction

        // Corner heights lose their fraction toward zero; the average of the
        // two whole parts is floored before it goes back to Q10.6.
        function int unsigned triangle_error(int unsigned lx, int unsigned lz,
                                             int unsigned rx, int unsigned rz);
            int hl;
            int hr;
            int hc;
            int avg;
            int d;
            hl  = height_at(lx, lz) / Q_ONE;
            hr  = height_at(rx, rz) / Q_ONE;
            hc  = height_at((lx + rx) >> 1, (lz + rz) >> 1);
            avg = (hl + hr + 2048) / 2 - 1024;
            d   = hc - avg * Q_ONE;
            return (d < 0) ? -d : d;
        endfunction

        function void push_frame(int slot, int unsigned lx, int unsigned lz,
                                 int unsigned rx, int unsigned rz,
                                 int unsigned ax, int unsigned az, int unsigned node);
            frame_crd[slot]   = '{lx, lz, rx, rz, ax, az};
            frame_node[slot]  = node;
            frame_phase[slot] = 0;
            frame_err[slot]   = triangle_error(lx, lz, rx, rz);
        endfunction

        // Depth first walk of one root triangle. With trace_only set nothing is
        // stored, so the walk only records which grid samples it reads.
        function int unsigned walk_tree(bit right, bit trace_only);
            int unsigned base;
            int unsigned root_err;
            int unsigned node;
            int unsigned cx;
            int unsigned cz;
            int          sp;
            int          t;
            bit          done;
            base     = right ? TREE_SIZE : 0;
            root_err = 0;
            if (right)
                push_frame(0, GRID_SPAN, GRID_SPAN, 0, 0, GRID_SPAN, 0, 1);
            else
                push_frame(0, 0, 0, GRID_SPAN, GRID_SPAN, 0, GRID_SPAN, 1);
            sp = 1;
            while (sp > 0)
            begin
                t    = sp - 1;
                node = frame_node[t];
                cx   = (frame_crd[t][0] + frame_crd[t][2]) >> 1;
                cz   = (frame_crd[t][1] + frame_crd[t][3]) >> 1;
                done = 1'b0;
                if (frame_phase[t] == 0)
                begin
                    if (node < TREE_SIZE && sp < STACK_DEPTH &&
                        (abs_diff(frame_crd[t][0], frame_crd[t][2]) >= SPLIT_MIN ||
                         abs_diff(frame_crd[t][1], frame_crd[t][3]) >= SPLIT_MIN))
                    begin
                        frame_phase[t] = 1;
                        push_frame(sp, frame_crd[t][4], frame_crd[t][5],
                                   frame_crd[t][0], frame_crd[t][1], cx, cz, node << 1);
                        sp++;
                    end
                    else
                        done = 1'b1;
                end
                else if (frame_phase[t] == 1)
                begin
                    frame_phase[t] = 2;
                    push_frame(sp, frame_crd[t][2], frame_crd[t][3],
                               frame_crd[t][4], frame_crd[t][5], cx, cz, (node << 1) + 1);
                    sp++;
                end
                else
                begin
                    if (!trace_only && node < TREE_SIZE)
                        variance_mem[base + node] = RES_W'(Q_ONE + frame_err[t]);
                    done = 1'b1;
                end
                if (done)
                begin
                    root_err = frame_err[t];
                    sp--;
                    if (sp > 0 && root_err > frame_err[sp - 1])
                        frame_err[sp - 1] = root_err;
                end
            end
            return root_err;
        endfunction

        function void mark_walk_samples();
            void'(walk_tree(1'b0, 1'b1));
            void'(walk_tree(1'b1, 1'b1));
        endfunction

        function void note_request(request_t rq);
            result_t want;
            int      idx;
            want.value  = '0;
            want.status = 1'b0;
            idx         = rq.x * GRID_DIM + rq.z;
            case (rq.kind)
                REQ_LOAD:
                begin
                    if (rq.x <= GRID_SPAN && rq.z <= GRID_SPAN)
                    begin
                        heights[idx] = rq.h;
                        loaded[idx]  = 1'b1;
                    end
                    else
                        want.status = 1'b1;
                end
                REQ_COMPUTE:
                    want.value = RES_W'(walk_tree(rq.tree, 1'b0));
                REQ_READ:
                begin
                    if (rq.node < TREE_SIZE)
                        want.value = variance_mem[(rq.tree ? TREE_SIZE : 0) + rq.node];
                end
                default:
                    ;
            endcase
            pending_results = {pending_results, want};
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("MISMATCH at %0t ns: %s", $time, msg);
        endfunction

        function void check_result(logic [RES_W-1:0] value, logic status);
            result_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result with no request waiting: value %0d status %0d",
                                 value, status));
                return;
            end
            want = pending_results.pop_front();
            if (value !== want.value)
                report($sformatf("result_value expected %0d, got %0d", want.value, value));
            if (status !== want.status)
                report($sformatf("status expected %0d, got %0d", want.status, status));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    // Percentages of cycles in which the sender holds back an item and in which
    // the receiver refuses one. A nonzero hold_request asks the receiver to keep
    // ready low for a hold whose length it gives.
    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;

    variance_scoreboard sb;

    rvt_req_if req_ch();
    rvt_rsp_if rsp_ch();

    roam_variance_tree_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #10 clk = ~clk;

    function automatic request_t make_req(logic [REQ_W-1:0] kind, int x, int z, int h,
                                          bit tree, int node);
        request_t rq;
        rq.kind = kind;
        rq.x    = XZ_W'(x);
        rq.z    = XZ_W'(z);
        rq.h    = H_W'(h);
        rq.tree = tree;
        rq.node = NUM_W'(node);
        return rq;
    endfunction

    // Heights lean toward the extremes and toward small values, where the
    // truncation of negative corners toward zero matters most.
    function automatic logic signed [H_W-1:0] random_height();
        int v;
        v = $urandom_range(400);
        case ($urandom_range(5))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return H_W'(v - 200);
            default: return H_W'($urandom_range(65535));
        endcase
    endfunction

    // Loads and reads make up most of the traffic. Computes are rare because
    // each one walks the whole tree; a few requests carry the unused code and
    // a tenth of the loads fall outside the grid.
    function automatic request_t random_request();
        request_t rq;
        int       pick;
        pick = $urandom_range(999);
        rq   = make_req(REQ_READ, $urandom_range(GRID_SPAN), $urandom_range(GRID_SPAN),
                        random_height(), 1'($urandom_range(1)),
                        $urandom_range(2 ** NUM_W - 1));
        if (pick < 10)
            rq.kind = REQ_COMPUTE;
        else if (pick < 40)
            rq.kind = REQ_UNUSED;
        else if (pick < 520)
        begin
            rq.kind = REQ_LOAD;
            if ($urandom_range(9) == 0)
            begin
                if ($urandom_range(1))
                begin
                    rq.x = XZ_W'($urandom_range(255, GRID_SPAN + 1));
                    rq.z = XZ_W'($urandom_range(255));
                end
                else
                begin
                    rq.x = XZ_W'($urandom_range(255));
                    rq.z = XZ_W'($urandom_range(255, GRID_SPAN + 1));
                end
            end
        end
        return rq;
    endfunction

    // Offers one item and returns at the edge where it is accepted. Valid stays
    // high on return so that back to back items need no gap.
    task automatic send_request(request_t rq);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= rq.kind;
        req_ch.grid_x       <= rq.x;
        req_ch.grid_z       <= rq.z;
        req_ch.height_value <= rq.h;
        req_ch.tree_select  <= rq.tree;
        req_ch.node_number  <= rq.node;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(rq);
    endtask

    // Stops offering items until every expected result has come back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_results.size() != 0);
    endtask

    // The receiver checks each accepted result item and then decides on ready
    // for the next cycle. A hold request is served here, counted in this process,
    // while the sender keeps offering items and the block backs up.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.result_value, rsp_ch.status);
            if (hold_request > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // The watchdog ends the run when no item moves on either channel for too
    // long. The clearing sweep after reset counts against it, well within reach.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        int idx;
        sb = new();
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_LOAD;
        req_ch.grid_x       <= '0;
        req_ch.grid_z       <= '0;
        req_ch.height_value <= '0;
        req_ch.tree_select  <= 1'b0;
        req_ch.node_number  <= '0;
        rsp_ch.ready        <= 1'b0;
        send_idle_pct = 12;
        recv_idle_pct = 55;
        hold_request  = 0;

        // A compute reads the same grid samples every time. Find them once so
        // that all of them are loaded before the first compute is sent.
        sb.mark_walk_samples();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reads before any compute see the store cleared by reset, including
        // node zero and the highest node number.
        send_request(make_req(REQ_READ, 0, 0, 0, 1'b0, 1));
        send_request(make_req(REQ_READ, 0, 0, 0, 1'b1, 0));
        send_request(make_req(REQ_READ, 0, 0, 0, 1'b1, 2 ** NUM_W - 1));
        send_request(make_req(REQ_UNUSED, 255, 255, -1, 1'b1, 2 ** NUM_W - 1));

        // Loads just past the grid edge and at the far corner of the field
        // range are ignored and flagged.
        send_request(make_req(REQ_LOAD, GRID_SPAN + 1, 0, 100, 1'b0, 0));
        send_request(make_req(REQ_LOAD, 0, 255, 100, 1'b0, 0));
        send_request(make_req(REQ_LOAD, 255, 255, -1, 1'b0, 0));

        // The root corners get the extreme heights, and the center gets a small
        // negative value whose whole part truncates toward zero.
        send_request(make_req(REQ_LOAD, 0, 0, -32768, 1'b0, 0));
        send_request(make_req(REQ_LOAD, GRID_SPAN, GRID_SPAN, 32767, 1'b0, 0));
        send_request(make_req(REQ_LOAD, 0, GRID_SPAN, -1, 1'b0, 0));
        send_request(make_req(REQ_LOAD, GRID_SPAN, 0, 16'sh7FC0, 1'b0, 0));
        send_request(make_req(REQ_LOAD, GRID_SPAN / 2, GRID_SPAN / 2, -65, 1'b0, 0));
        wait_drained();

        // Fill every sample that a compute reads and that is still unwritten.
        for (idx = 0; idx < GRID_DEPTH; idx++)
        begin
            if (sb.touched[idx] && !sb.loaded[idx])
                send_request(make_req(REQ_LOAD, idx / GRID_DIM, idx % GRID_DIM,
                                      random_height(), 1'b0, 0));
        end

        // Both roots, then reads of the root, of deep nodes and of node zero.
        send_request(make_req(REQ_COMPUTE, 0, 0, 0, 1'b0, 0));
        send_request(make_req(REQ_COMPUTE, 0, 0, 0, 1'b1, 0));
        send_request(make_req(REQ_READ, 0, 0, 0, 1'b0, 1));
        send_request(make_req(REQ_READ, 0, 0, 0, 1'b1, 1));
        send_request(make_req(REQ_READ, 0, 0, 0, 1'b0, 2 ** NUM_W - 1));
        send_request(make_req(REQ_READ, 0, 0, 0, 1'b1, TREE_SIZE / 2));
        send_request(make_req(REQ_READ, 0, 0, 0, 1'b0, 0));

        // Change a sample near the origin, the center and a corner, then walk again so that stored
        // entries are overwritten.
        send_request(make_req(REQ_LOAD, 1, 1, 12345, 1'b0, 0));
        send_request(make_req(REQ_LOAD, GRID_SPAN / 2, GRID_SPAN / 2, 32767, 1'b0, 0));
        send_request(make_req(REQ_LOAD, GRID_SPAN, GRID_SPAN, -32768, 1'b0, 0));
        send_request(make_req(REQ_COMPUTE, 0, 0, 0, 1'b0, 0));
        send_request(make_req(REQ_COMPUTE, 0, 0, 0, 1'b1, 0));
        send_request(make_req(REQ_READ, 0, 0, 0, 1'b0, 1));
        wait_drained();

        // Random traffic in three parts: a slow receiver, then a slow sender,
        // then neither idles. Each part makes the receiver hold off once for a
        // long stretch, and the sender waits for all results between parts.
        for (int part = 0; part < 3; part++)
        begin
            send_idle_pct = (part == 0) ? 12 : (part == 1) ? 55 : 0;
            recv_idle_pct = (part == 0) ? 55 : (part == 1) ? 12 : 0;
            for (int i = 0; i < RANDOM_ITEMS / 3; i++)
            begin
                if (i == 50)
                    hold_request = HOLD_CYCLES;
                send_request(random_request());
            end
            wait_drained();
        end

        // Late or stray result items would show up as unexpected here.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
